### hdl/sprite_row_fetch_and_fifo_merge_core_defines.svh
// assertion macros shared by the sprite fetch and merge rtl
// no dependencies; included by the files that carry assertions
`ifndef SPRITE_ROW_FETCH_AND_FIFO_MERGE_CORE_DEFINES_SVH
`define SPRITE_ROW_FETCH_AND_FIFO_MERGE_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SRFM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("srfm assertion failed");

// next-cycle implication, checked outside reset
`define SRFM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("srfm assertion failed");

`endif

### hdl/srfm_pkg.sv
// types, codes and constants for the sprite row fetch and pixel fifo merge
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package srfm_pkg;

    localparam int FIFO_DEPTH = 8;
    localparam int S_TDATA_W  = 64;
    localparam int M_TDATA_W  = 40;
    localparam int X_OFFSET   = 8;
    localparam int X_RANK_MAX = 175;

    typedef enum logic [1:0] {
        OP_FETCH = 2'd0,
        OP_MERGE = 2'd1,
        OP_POP   = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    typedef enum logic [0:0] {
        REG_COLOR_MODE   = 1'b0,
        REG_TALL_SPRITES = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic color_mode;
        logic tall_sprites;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  color;
        logic [2:0]  palette;
        logic [16:0] rank;
        logic        filler;
    } pixel_t;

    // attributes latched by a fetch
    typedef struct packed {
        logic [8:0] sx;
        logic [5:0] idx;
        logic [2:0] pal;
        logic       behind;
        logic       fx;
    } sprite_t;

    // shared by all lanes during a merge
    typedef struct packed {
        logic [7:0]  rx;
        logic [8:0]  sx;
        logic [7:0]  lo;
        logic [7:0]  hi;
        logic        fx;
        logic [2:0]  pal;
        logic [15:0] rank_mag;
        logic [16:0] rank_stored;
    } merge_ctx_t;

endpackage

### hdl/srfm_fetch.sv
// row address generation and sprite attribute latch
// depends on srfm_pkg
`timescale 1ns / 1ps

module srfm_fetch (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load,
    input  srfm_pkg::cfg_t      cfg,
    input  logic [7:0]          tile_id,
    input  logic signed [8:0]   sprite_y,
    input  logic signed [8:0]   sprite_x,
    input  logic [5:0]          obj_index,
    input  logic                flip_x,
    input  logic                flip_y,
    input  logic                behind_bg,
    input  logic [2:0]          palette,
    input  logic                vram_bank,
    input  logic [7:0]          line,
    output logic [11:0]         address,
    output logic                bank,
    output srfm_pkg::sprite_t   sprite
);

    srfm_pkg::sprite_t sprite_reg, sprite_next;
    logic [3:0] diff;
    logic [3:0] row;

    // row within the sprite, wrapped to the sprite height
    always_comb begin
        diff = line[3:0] - sprite_y[3:0];
        if (cfg.tall_sprites) begin
            row = flip_y ? ~diff : diff;
        end else begin
            row = {1'b0, flip_y ? ~diff[2:0] : diff[2:0]};
        end
    end

    // sixteen bytes per tile, two per row; tall sprites pick the tile by row bit 3
    assign address = {tile_id[7:1], cfg.tall_sprites ? row[3] : tile_id[0], row[2:0], 1'b0};
    assign bank    = cfg.color_mode & vram_bank;

    always_comb begin
        sprite_next = sprite_reg;
        if (load) begin
            sprite_next.sx     = sprite_x;
            sprite_next.idx    = obj_index;
            sprite_next.pal    = palette;
            sprite_next.behind = behind_bg;
            sprite_next.fx     = flip_x;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sprite_reg <= '0;
        end else begin
            sprite_reg <= sprite_next;
        end
    end

    assign sprite = sprite_reg;

endmodule

### hdl/srfm_lane.sv
// one fifo slot of the merge: picks its sprite pixel and decides replacement
// depends on srfm_pkg
`timescale 1ns / 1ps

module srfm_lane #(
    parameter int LANE_IDX = 0
) (
    input  srfm_pkg::merge_ctx_t ctx,
    input  srfm_pkg::pixel_t     old_px,
    output srfm_pkg::pixel_t     new_px
);

    logic [10:0] px;
    logic        in_range;
    logic [2:0]  bit_sel;
    logic [1:0]  col;
    logic [16:0] old_mag;
    logic        take;

    always_comb begin
        // sprite column that lands on this slot
        px       = 11'(LANE_IDX) + {3'b000, ctx.rx} - {{2{ctx.sx[8]}}, ctx.sx};
        in_range = (px[10:3] == 8'd0);
        bit_sel  = ctx.fx ? px[2:0] : ~px[2:0];
        col      = {ctx.hi[bit_sel], ctx.lo[bit_sel]};
        old_mag  = old_px.rank[16] ? ~old_px.rank : old_px.rank;
        take     = in_range && (col != 2'd0) &&
                   ((old_px.color == 2'd0) || ({1'b0, ctx.rank_mag} < old_mag));
        new_px   = old_px;
        if (take) begin
            new_px.color   = col;
            new_px.palette = ctx.pal;
            new_px.rank    = ctx.rank_stored;
            new_px.filler  = 1'b0;
        end
    end

endmodule

### hdl/srfm_fifo.sv
// object pixel fifo: slot storage, padding, parallel merge lanes, pop and clear
// depends on srfm_pkg, srfm_lane and the assertion macro header
`timescale 1ns / 1ps
`include "sprite_row_fetch_and_fifo_merge_core_defines.svh"

module srfm_fifo #(
    parameter int FIFO_DEPTH = srfm_pkg::FIFO_DEPTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                accept,
    input  srfm_pkg::op_t       op,
    input  logic                color_mode,
    input  srfm_pkg::sprite_t   sprite,
    input  logic [7:0]          rx,
    input  logic [15:0]         tile_data,
    output logic                pop_valid,
    output srfm_pkg::pixel_t    pop_px
);

    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    srfm_pkg::pixel_t slot_reg [FIFO_DEPTH];
    srfm_pkg::pixel_t slot_next [FIFO_DEPTH];
    srfm_pkg::pixel_t padded [FIFO_DEPTH];
    srfm_pkg::pixel_t merged [FIFO_DEPTH];
    logic [CNT_W-1:0] count_reg, count_next;

    srfm_pkg::merge_ctx_t ctx;
    logic signed [9:0] xp;
    logic [7:0]        xp_clamped;
    logic [15:0]       rank;

    // rank: oam index in colour mode, else clamped x+8 above the index
    always_comb begin
        xp = {sprite.sx[8], sprite.sx} + 10'(srfm_pkg::X_OFFSET);
        if (xp < 10'sd0) begin
            xp_clamped = 8'd0;
        end else if (xp > 10'(srfm_pkg::X_RANK_MAX)) begin
            xp_clamped = 8'(srfm_pkg::X_RANK_MAX);
        end else begin
            xp_clamped = xp[7:0];
        end
        rank = color_mode ? {10'd0, sprite.idx} : {xp_clamped, 2'b00, sprite.idx};
        ctx.rx          = rx;
        ctx.sx          = sprite.sx;
        ctx.lo          = tile_data[7:0];
        ctx.hi          = tile_data[15:8];
        ctx.fx          = sprite.fx;
        ctx.pal         = sprite.pal;
        ctx.rank_mag    = rank;
        ctx.rank_stored = sprite.behind ? ~{1'b0, rank} : {1'b0, rank};
    end

    for (genvar g = 0; g < FIFO_DEPTH; g++) begin : g_lane
        // slots past the fill level become transparent filler first
        always_comb begin
            if (CNT_W'(g) >= count_reg) begin
                padded[g] = '{color: 2'd0, palette: 3'd0, rank: 17'd0, filler: 1'b1};
            end else begin
                padded[g] = slot_reg[g];
            end
        end

        srfm_lane #(
            .LANE_IDX (g)
        ) u_lane (
            .ctx    (ctx),
            .old_px (padded[g]),
            .new_px (merged[g])
        );
    end

    always_comb begin
        slot_next  = slot_reg;
        count_next = count_reg;
        if (accept) begin
            unique case (op)
                srfm_pkg::OP_FETCH: begin
                end
                srfm_pkg::OP_MERGE: begin
                    slot_next  = merged;
                    count_next = CNT_W'(FIFO_DEPTH);
                end
                srfm_pkg::OP_POP: begin
                    if (count_reg != '0) begin
                        for (int i = 0; i < FIFO_DEPTH - 1; i++) begin
                            slot_next[i] = slot_reg[i+1];
                        end
                        slot_next[FIFO_DEPTH-1] = '0;
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                srfm_pkg::OP_CLEAR: begin
                    for (int i = 0; i < FIFO_DEPTH; i++) begin
                        slot_next[i] = '0;
                    end
                    count_next = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // slots at or above the fill level are never read before being padded
    always_ff @(posedge aclk) begin
        slot_reg <= slot_next;
    end

    assign pop_valid = (count_reg != '0);
    assign pop_px    = pop_valid ? slot_reg[0] : '0;

    `SRFM_ASSERT_NEXT(a_merge_fills, aclk, aresetn, accept && (op == srfm_pkg::OP_MERGE), count_reg == CNT_W'(FIFO_DEPTH))
    `SRFM_ASSERT_NEXT(a_clear_empties, aclk, aresetn, accept && (op == srfm_pkg::OP_CLEAR), count_reg == '0)
    `SRFM_ASSERT_NEXT(a_pop_decrements, aclk, aresetn, accept && (op == srfm_pkg::OP_POP) && (count_reg != '0), count_reg == $past(count_reg) - CNT_W'(1))

endmodule

### hdl/sprite_row_fetch_and_fifo_merge_core.sv
// top level of the sprite row fetch and object pixel fifo merge
// depends on srfm_pkg, srfm_fetch, srfm_fifo and the assertion macro header
//
// channel   | direction | handshake                  | contents
// ----------+-----------+----------------------------+---------------------------------
// s_axis    | in        | tvalid / tready            | tuser opcode, tdata sprite fields
// m_axis    | out       | tvalid / tready            | tuser kind, tdata address/pixel
// cfg       | in        | cfg_wr_en, no back-pressure| cfg_addr register, cfg_wdata value
//
// every transfer on s_axis puts exactly one result on m_axis the cycle after
// a merge compares all eight fifo slots at once, one lane per slot, so one item per cycle
// the single output register sets the rate: a new item is taken whenever it is empty
// or being drained in the same cycle, so a stall on m_axis holds s_axis off directly
// reset (aresetn low, synchronous) empties the fifo, clears the latches and config
`timescale 1ns / 1ps
`include "sprite_row_fetch_and_fifo_merge_core_defines.svh"

module sprite_row_fetch_and_fifo_merge_core #(
    parameter int FIFO_DEPTH = srfm_pkg::FIFO_DEPTH
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration writes
    input  logic                            cfg_wr_en,
    input  logic [0:0]                      cfg_addr,
    input  logic [0:0]                      cfg_wdata,
    // input items
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // tile_id[7:0] sprite_y[16:8] sprite_x[25:17] obj_index[31:26] flip_x[32]
    // flip_y[33] behind_bg[34] palette[37:35] vram_bank[38] line_or_x[46:39]
    // tile_data[62:47], bit 63 zero
    input  logic [srfm_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // opcode[1:0]
    input  logic [1:0]                      s_axis_tuser,
    // result items
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // address[11:0] bank[12] pixel_valid[13] pixel_color[15:14]
    // pixel_palette[18:16] pixel_rank[35:19] pixel_filler[36], bits 39:37 zero
    output logic [srfm_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    // kind[1:0]
    output logic [1:0]                      m_axis_tuser
);

    // configuration registers
    srfm_pkg::cfg_t cfg_reg, cfg_next;

    // output register
    logic               m_valid_reg, m_valid_next;
    logic [1:0]         kind_reg, kind_next;
    logic [11:0]        address_reg, address_next;
    logic               bank_reg, bank_next;
    logic               pvalid_reg, pvalid_next;
    srfm_pkg::pixel_t   px_reg, px_next;

    // input field unpacking
    srfm_pkg::op_t      op;
    logic [7:0]         tile_id;
    logic signed [8:0]  sprite_y;
    logic signed [8:0]  sprite_x;
    logic [5:0]         obj_index;
    logic               flip_x;
    logic               flip_y;
    logic               behind_bg;
    logic [2:0]         palette;
    logic               vram_bank;
    logic [7:0]         line_or_x;
    logic [15:0]        tile_data;

    logic               s_xfer;
    logic [11:0]        fetch_address;
    logic               fetch_bank;
    srfm_pkg::sprite_t  sprite;
    logic               pop_valid;
    srfm_pkg::pixel_t   pop_px;

    assign op        = srfm_pkg::op_t'(s_axis_tuser);
    assign tile_id   = s_axis_tdata[7:0];
    assign sprite_y  = s_axis_tdata[16:8];
    assign sprite_x  = s_axis_tdata[25:17];
    assign obj_index = s_axis_tdata[31:26];
    assign flip_x    = s_axis_tdata[32];
    assign flip_y    = s_axis_tdata[33];
    assign behind_bg = s_axis_tdata[34];
    assign palette   = s_axis_tdata[37:35];
    assign vram_bank = s_axis_tdata[38];
    assign line_or_x = s_axis_tdata[46:39];
    assign tile_data = s_axis_tdata[62:47];

    // take a new item while the output register is empty or being drained
    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign s_xfer        = s_axis_tvalid && s_axis_tready;

    // configuration writes, taken at any time the enable is high
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            if (cfg_addr == srfm_pkg::REG_COLOR_MODE) begin
                cfg_next.color_mode = cfg_wdata[0];
            end
            if (cfg_addr == srfm_pkg::REG_TALL_SPRITES) begin
                cfg_next.tall_sprites = cfg_wdata[0];
            end
        end
    end

    // row address and attribute latch
    srfm_fetch u_fetch (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (s_xfer && (op == srfm_pkg::OP_FETCH)),
        .cfg       (cfg_reg),
        .tile_id   (tile_id),
        .sprite_y  (sprite_y),
        .sprite_x  (sprite_x),
        .obj_index (obj_index),
        .flip_x    (flip_x),
        .flip_y    (flip_y),
        .behind_bg (behind_bg),
        .palette   (palette),
        .vram_bank (vram_bank),
        .line      (line_or_x),
        .address   (fetch_address),
        .bank      (fetch_bank),
        .sprite    (sprite)
    );

    // pixel fifo with one merge lane per slot
    srfm_fifo #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (s_xfer),
        .op         (op),
        .color_mode (cfg_reg.color_mode),
        .sprite     (sprite),
        .rx         (line_or_x),
        .tile_data  (tile_data),
        .pop_valid  (pop_valid),
        .pop_px     (pop_px)
    );

    // result assembly; fields not belonging to the opcode read as zero
    always_comb begin
        m_valid_next = m_valid_reg;
        kind_next    = kind_reg;
        address_next = address_reg;
        bank_next    = bank_reg;
        pvalid_next  = pvalid_reg;
        px_next      = px_reg;
        if (m_valid_reg && m_axis_tready) begin
            m_valid_next = 1'b0;
        end
        if (s_xfer) begin
            m_valid_next = 1'b1;
            kind_next    = s_axis_tuser;
            address_next = '0;
            bank_next    = 1'b0;
            pvalid_next  = 1'b0;
            px_next      = '0;
            unique case (op)
                srfm_pkg::OP_FETCH: begin
                    address_next = fetch_address;
                    bank_next    = fetch_bank;
                end
                srfm_pkg::OP_POP: begin
                    pvalid_next = pop_valid;
                    px_next     = pop_px;
                end
                srfm_pkg::OP_MERGE, srfm_pkg::OP_CLEAR: begin
                end
                default: begin
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            cfg_reg     <= cfg_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        kind_reg    <= kind_next;
        address_reg <= address_next;
        bank_reg    <= bank_next;
        pvalid_reg  <= pvalid_next;
        px_reg      <= px_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = kind_reg;
    assign m_axis_tdata  = {3'b000, px_reg.filler, px_reg.rank, px_reg.palette,
                            px_reg.color, pvalid_reg, bank_reg, address_reg};

    `SRFM_ASSERT_NEXT(a_xfer_yields_result, aclk, aresetn, s_xfer, m_valid_reg)
    `SRFM_ASSERT_NEXT(a_kind_follows_opcode, aclk, aresetn, s_xfer, kind_reg == $past(s_axis_tuser))
    `SRFM_ASSERT_IMP(a_pixel_only_on_pop, aclk, aresetn, m_valid_reg && (kind_reg != srfm_pkg::OP_POP), !pvalid_reg && (px_reg == '0))

endmodule

### tb/sprite_row_fetch_and_fifo_merge_core_tb.sv
// self-checking bench for the sprite row fetch and object pixel fifo merge core
// depends on srfm_pkg and sprite_row_fetch_and_fifo_merge_core; a built-in predictor
// shadows the fifo and the latches and checks every result transfer field by field
`timescale 1ns / 1ps

module sprite_row_fetch_and_fifo_merge_core_tb;

    localparam int HALF_PERIOD     = 4;
    localparam int SPRITE_W        = 8;
    localparam int TILE_BYTES      = 16;
    localparam int RANK_X_SCALE    = 256;
    localparam int IDLE_PCT        = 11;
    localparam int ITEMS_PER_PHASE = 160;
    localparam int PRINT_LIMIT     = 50;

    // one input item, unpacked the way the sprite fields are named
    typedef struct {
        srfm_pkg::op_t     op;
        logic [7:0]        tile;
        logic signed [8:0] sy;
        logic signed [8:0] sx;
        logic [5:0]        idx;
        logic              fx;
        logic              fy;
        logic              behind;
        logic [2:0]        pal;
        logic              bank;
        logic [7:0]        lx;
        logic [15:0]       tdat;
    } sprite_item_t;

    // one result item
    typedef struct {
        logic [1:0]  kind;
        logic [11:0] addr;
        logic        bank;
        logic        valid;
        logic [1:0]  color;
        logic [2:0]  pal;
        logic [16:0] rank;
        logic        filler;
    } fifo_result_t;

    // dut ports, all inputs known from time zero
    logic                             aclk          = 1'b0;
    logic                             aresetn       = 1'b0;
    logic                             cfg_wr_en     = 1'b0;
    logic [0:0]                       cfg_addr      = '0;
    logic [0:0]                       cfg_wdata     = '0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [srfm_pkg::S_TDATA_W-1:0]   s_axis_tdata  = '0;
    logic [1:0]                       s_axis_tuser  = '0;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic [srfm_pkg::M_TDATA_W-1:0]   m_axis_tdata;
    logic [1:0]                       m_axis_tuser;

    // shadow of the block: config, latched sprite, object pixel fifo
    srfm_pkg::cfg_t    mdl_cfg = '0;
    srfm_pkg::sprite_t spr_latch = '0;
    srfm_pkg::pixel_t  obj_fifo [srfm_pkg::FIFO_DEPTH] = '{default: '0};
    int                obj_count = 0;

    sprite_item_t pending_items[$];
    fifo_result_t expected_results[$];
    sprite_item_t item_on_bus;
    int           mismatch_count = 0;
    // no random idling on either side while set
    logic         calm = 1'b0;

    sprite_row_fetch_and_fifo_merge_core i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #HALF_PERIOD aclk = 1'b1;
        #HALF_PERIOD aclk = 1'b0;
    end

    task automatic report_mismatch(string msg);
        if (mismatch_count < PRINT_LIMIT) begin
            $display("%0t ns: mismatch: %0s", $time, msg);
        end
        mismatch_count++;
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%0s got %0h want %0h", name, got, want));
        end
    endtask

    // advance the shadow by one item and return the result it should produce
    function automatic fifo_result_t predict_sprite_op(sprite_item_t it);
        fifo_result_t res;
        int           hmask, row, tile_n, sx_i, r_mag, first_px, px, slot, bit_pos, k;
        logic [16:0]  stored, old_rank;
        logic [1:0]   col;
        res = '{default: '0};
        res.kind = it.op;
        case (it.op)
            srfm_pkg::OP_FETCH: begin
                // row inside the sprite wraps on its height
                hmask = mdl_cfg.tall_sprites ? 15 : 7;
                row = (int'(it.lx) - int'(it.sy)) & hmask;
                if (it.fy) begin
                    row = hmask - row;
                end
                tile_n = int'(it.tile);
                // tall sprites: even tile on top, odd tile for the bottom half
                if (mdl_cfg.tall_sprites) begin
                    tile_n = tile_n & 'hFE;
                    if (row >= SPRITE_W) begin
                        tile_n = tile_n | 1;
                        row = row - SPRITE_W;
                    end
                end
                res.addr = 12'(tile_n * TILE_BYTES + row * 2);
                res.bank = mdl_cfg.color_mode & it.bank;
                spr_latch.sx = it.sx;
                spr_latch.idx = it.idx;
                spr_latch.pal = it.pal;
                spr_latch.behind = it.behind;
                spr_latch.fx = it.fx;
            end
            srfm_pkg::OP_MERGE: begin
                // top up with transparent filler first
                while (obj_count < srfm_pkg::FIFO_DEPTH) begin
                    obj_fifo[obj_count] = '{color: 2'd0, palette: 3'd0, rank: 17'd0,
                                            filler: 1'b1};
                    obj_count++;
                end
                sx_i = int'($signed(spr_latch.sx));
                if (mdl_cfg.color_mode) begin
                    r_mag = int'(spr_latch.idx);
                end else begin
                    // monochrome: leftmost sprite first, x saturated
                    r_mag = sx_i + srfm_pkg::X_OFFSET;
                    if (r_mag < 0) begin
                        r_mag = 0;
                    end
                    if (r_mag > srfm_pkg::X_RANK_MAX) begin
                        r_mag = srfm_pkg::X_RANK_MAX;
                    end
                    r_mag = r_mag * RANK_X_SCALE + int'(spr_latch.idx);
                end
                stored = r_mag[16:0];
                if (spr_latch.behind) begin
                    stored = ~stored;
                end
                first_px = (sx_i < 0) ? -sx_i : 0;
                for (px = first_px; px < SPRITE_W; px++) begin
                    slot = sx_i + px - int'(it.lx);
                    if (slot < 0 || slot >= srfm_pkg::FIFO_DEPTH) begin
                        continue;
                    end
                    bit_pos = spr_latch.fx ? px : SPRITE_W - 1 - px;
                    col = {it.tdat[SPRITE_W + bit_pos], it.tdat[bit_pos]};
                    if (col == 2'd0) begin
                        continue;
                    end
                    // compare magnitudes, the behind flag never decides
                    old_rank = obj_fifo[slot].rank;
                    if (old_rank[16]) begin
                        old_rank = ~old_rank;
                    end
                    if (obj_fifo[slot].color == 2'd0 || r_mag < int'(old_rank)) begin
                        obj_fifo[slot] = '{color: col, palette: spr_latch.pal, rank: stored,
                                           filler: 1'b0};
                    end
                end
            end
            srfm_pkg::OP_POP: begin
                if (obj_count > 0) begin
                    res.valid = 1'b1;
                    res.color = obj_fifo[0].color;
                    res.pal = obj_fifo[0].palette;
                    res.rank = obj_fifo[0].rank;
                    res.filler = obj_fifo[0].filler;
                    for (k = 0; k < srfm_pkg::FIFO_DEPTH - 1; k++) begin
                        obj_fifo[k] = obj_fifo[k + 1];
                    end
                    obj_fifo[srfm_pkg::FIFO_DEPTH - 1] = '0;
                    obj_count--;
                end
            end
            default: begin
                for (k = 0; k < srfm_pkg::FIFO_DEPTH; k++) begin
                    obj_fifo[k] = '0;
                end
                obj_count = 0;
            end
        endcase
        return res;
    endfunction

    function automatic sprite_item_t mk_item(srfm_pkg::op_t op, int tile, int sy, int sx,
                                             int idx, int fx, int fy, int behind, int pal,
                                             int bank, int lx, int tdat);
        sprite_item_t it;
        it.op = op;
        it.tile = 8'(tile);
        it.sy = 9'(sy);
        it.sx = 9'(sx);
        it.idx = 6'(idx);
        it.fx = 1'(fx);
        it.fy = 1'(fy);
        it.behind = 1'(behind);
        it.pal = 3'(pal);
        it.bank = 1'(bank);
        it.lx = 8'(lx);
        it.tdat = 16'(tdat);
        return it;
    endfunction

    // every field random; sprite x mostly on screen, now and then anywhere in 9 bits
    function automatic sprite_item_t rand_item(srfm_pkg::op_t op);
        sprite_item_t it;
        it.op = op;
        it.tile = 8'($urandom_range(255));
        it.sy = 9'($urandom_range(175) - 16);
        it.sx = ($urandom_range(9) == 0) ? 9'($urandom_range(511))
                                         : 9'($urandom_range(175) - 8);
        it.idx = 6'($urandom_range(39));
        it.fx = 1'($urandom_range(1));
        it.fy = 1'($urandom_range(1));
        it.behind = 1'($urandom_range(1));
        it.pal = 3'($urandom_range(7));
        it.bank = 1'($urandom_range(1));
        it.lx = 8'($urandom_range(255));
        case ($urandom_range(15))
            0:       it.tdat = 16'h0000;
            1:       it.tdat = 16'hFFFF;
            default: it.tdat = 16'($urandom_range(16'hFFFF));
        endcase
        return it;
    endfunction

    task automatic push_pops(int n);
        repeat (n) begin
            pending_items.push_back(rand_item(srfm_pkg::OP_POP));
        end
    endtask

    // mostly whole scanline bursts: up to three sprites merged at one renderer x,
    // then pops; the rest is loose pops, clears and fully random items
    task automatic gen_random(int n_items);
        sprite_item_t it;
        int made, rx, n_spr, n_pop, h, choice;
        made = 0;
        h = mdl_cfg.tall_sprites ? 2 * SPRITE_W : SPRITE_W;
        while (made < n_items) begin
            choice = $urandom_range(99);
            if (choice < 70) begin
                rx = $urandom_range(160);
                n_spr = $urandom_range(1, 3);
                repeat (n_spr) begin
                    it = rand_item(srfm_pkg::OP_FETCH);
                    if ($urandom_range(9) != 0) begin
                        it.sx = 9'(rx + $urandom_range(14) - 7);
                    end
                    // scanline normally inside the sprite, sometimes anywhere
                    if ($urandom_range(9) != 0) begin
                        it.lx = 8'(it.sy + $urandom_range(h - 1));
                    end
                    pending_items.push_back(it);
                    it = rand_item(srfm_pkg::OP_MERGE);
                    it.lx = 8'(rx);
                    pending_items.push_back(it);
                    made += 2;
                end
                n_pop = $urandom_range(1, srfm_pkg::FIFO_DEPTH + 1);
                push_pops(n_pop);
                made += n_pop;
            end else if (choice < 85) begin
                n_pop = $urandom_range(1, 4);
                push_pops(n_pop);
                made += n_pop;
            end else if (choice < 92) begin
                pending_items.push_back(rand_item(srfm_pkg::OP_CLEAR));
                made++;
            end else begin
                pending_items.push_back(rand_item(srfm_pkg::op_t'($urandom_range(3))));
                made++;
            end
        end
    endtask

    // only called with the block idle
    task automatic set_config(logic cm, logic tall);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= srfm_pkg::REG_COLOR_MODE;
        cfg_wdata <= cm;
        @(posedge aclk);
        cfg_addr <= srfm_pkg::REG_TALL_SPRITES;
        cfg_wdata <= tall;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        mdl_cfg.color_mode = cm;
        mdl_cfg.tall_sprites = tall;
    endtask

    // everything sent and every result back; looked at mid-cycle once the edge settled
    task automatic drain;
        while (pending_items.size() != 0 || s_axis_tvalid || expected_results.size() != 0) begin
            @(negedge aclk);
        end
        repeat (2) @(posedge aclk);
    endtask

    // input driver: next item once the current transfer is done, random gaps
    always @(posedge aclk) begin
        sprite_item_t nx;
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (pending_items.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                nx = pending_items.pop_front();
                item_on_bus <= nx;
                s_axis_tvalid <= 1'b1;
                s_axis_tuser <= nx.op;
                s_axis_tdata <= {1'b0, nx.tdat, nx.lx, nx.bank, nx.pal, nx.behind, nx.fy,
                                 nx.fx, nx.idx, nx.sx, nx.sy, nx.tile};
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result side back-pressure
    always @(posedge aclk) begin
        m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    // monitor: check the result transfer first, then predict for the input transfer
    always @(posedge aclk) begin
        fifo_result_t want;
        if (aresetn) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result with nothing pending, tuser %0h tdata %0h",
                                              m_axis_tuser, m_axis_tdata));
                end else begin
                    want = expected_results.pop_front();
                    check_field("kind", 32'(m_axis_tuser), 32'(want.kind));
                    check_field("address", 32'(m_axis_tdata[11:0]), 32'(want.addr));
                    check_field("bank", 32'(m_axis_tdata[12]), 32'(want.bank));
                    check_field("pixel_valid", 32'(m_axis_tdata[13]), 32'(want.valid));
                    check_field("pixel_color", 32'(m_axis_tdata[15:14]), 32'(want.color));
                    check_field("pixel_palette", 32'(m_axis_tdata[18:16]), 32'(want.pal));
                    check_field("pixel_rank", 32'(m_axis_tdata[35:19]), 32'(want.rank));
                    check_field("pixel_filler", 32'(m_axis_tdata[36]), 32'(want.filler));
                    check_field("tdata padding", 32'(m_axis_tdata[39:37]), '0);
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                expected_results.push_back(predict_sprite_op(item_on_bus));
            end
        end
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // phase 1: monochrome, 8x8
        set_config(1'b0, 1'b0);
        // pop from an empty fifo, then a merge on the reset latches
        pending_items.push_back(mk_item(srfm_pkg::OP_POP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_items.push_back(mk_item(srfm_pkg::OP_MERGE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
                                        16'hFFFF));
        pending_items.push_back(mk_item(srfm_pkg::OP_POP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_items.push_back(mk_item(srfm_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        // fields mostly high, sprite hanging off the left edge, behind the background
        pending_items.push_back(mk_item(srfm_pkg::OP_FETCH, 255, -16, -3, 39, 1, 1, 1, 7, 1,
                                        255, 0));
        pending_items.push_back(mk_item(srfm_pkg::OP_MERGE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
                                        16'h00FF));
        // right edge of the screen, part of the row lands
        pending_items.push_back(mk_item(srfm_pkg::OP_FETCH, 0, 159, 167, 0, 0, 0, 0, 0, 0,
                                        0, 0));
        pending_items.push_back(mk_item(srfm_pkg::OP_MERGE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 165,
                                        16'hFF00));
        // x past either end of the rank saturation
        pending_items.push_back(mk_item(srfm_pkg::OP_FETCH, 85, 20, 255, 5, 0, 1, 0, 3, 0,
                                        23, 16'h5555));
        pending_items.push_back(mk_item(srfm_pkg::OP_MERGE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 250,
                                        16'hFFFF));
        pending_items.push_back(mk_item(srfm_pkg::OP_FETCH, 170, 40, -200, 1, 1, 0, 1, 4, 1,
                                        44, 0));
        pending_items.push_back(mk_item(srfm_pkg::OP_MERGE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
                                        16'hFFFF));
        // overlapping sprites: the smaller rank wins whatever its behind flag
        pending_items.push_back(mk_item(srfm_pkg::OP_FETCH, 3, 0, 12, 20, 0, 0, 0, 2, 0, 5, 0));
        pending_items.push_back(mk_item(srfm_pkg::OP_MERGE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 10,
                                        16'hF0F0));
        pending_items.push_back(mk_item(srfm_pkg::OP_FETCH, 4, 0, 10, 9, 0, 0, 1, 6, 0, 5, 0));
        pending_items.push_back(mk_item(srfm_pkg::OP_MERGE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 10,
                                        16'h0FFF));
        // empty it and pop once more
        push_pops(srfm_pkg::FIFO_DEPTH + 1);
        gen_random(ITEMS_PER_PHASE);
        drain();

        // phase 2: colour mode, 8x8
        set_config(1'b1, 1'b0);
        gen_random(ITEMS_PER_PHASE);
        drain();

        // phase 3: monochrome, 8x16, with both sides streaming back to back
        calm <= 1'b1;
        set_config(1'b0, 1'b1);
        gen_random(ITEMS_PER_PHASE);
        drain();
        calm <= 1'b0;

        // phase 4: colour mode, 8x16
        set_config(1'b1, 1'b1);
        gen_random(ITEMS_PER_PHASE);
        drain();

        repeat (3) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("sprite_row_fetch_and_fifo_merge_core_tb: done, clean");
        end else begin
            $display("sprite_row_fetch_and_fifo_merge_core_tb: done, errors");
        end
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial begin
        #2000000;
        $display("sprite_row_fetch_and_fifo_merge_core_tb: done, errors");
        $finish;
    end

endmodule

### filelist.f
+incdir+hdl
hdl/srfm_pkg.sv
hdl/srfm_fetch.sv
hdl/srfm_lane.sv
hdl/srfm_fifo.sv
hdl/sprite_row_fetch_and_fifo_merge_core.sv
tb/sprite_row_fetch_and_fifo_merge_core_tb.sv
